[rtl/vr3d_pkg.sv]
// package for vector_refract_3d: payload types and width helpers
`timescale 1ns / 1ps

package vr3d_pkg;

  typedef struct packed {
    logic signed [15:0] incident_x;
    logic signed [15:0] incident_y;
    logic signed [15:0] incident_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        [15:0] eta;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               total_reflection;
    logic               saturated;
  } out_t;

  localparam int CompW = 16;
  localparam int CompMax = 32767;
  localparam int CompMin = -32768;

  function automatic int maxi(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

[rtl/vector_refract_3d.sv]
// vector_refract_3d: pipelined snell refraction of a 3d vector in fixed point
// the square root result has SW bits, where SW is 22 at FRAC_BITS = 14
// throughput: one item per cycle unless stalled; one square root bit per stage
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset clears only the stage valid bits, the pipeline comes up empty
`timescale 1ns / 1ps

module vector_refract_3d #(
  parameter int FRAC_BITS = 14
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  vr3d_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output vr3d_pkg::out_t  out_data_o
);
  import vr3d_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int DOTW = 33;
  localparam int DW   = DOTW - F;
  localparam int TW   = maxi(2 * DW - F, F + 1) + 1;
  localparam int E2W  = maxi(32 - F, 1);
  localparam int PW   = maxi(E2W + 1 + TW - F, 2);
  localparam int KW   = maxi(PW, F + 2) + 1;
  localparam int RADW = KW - 1 + F;
  localparam int SW   = (RADW + 1) / 2;
  localparam int RW   = SW + 2;
  localparam int EDW  = maxi(17 + DW - F, 2);
  localparam int MUW  = maxi(EDW, SW + 1) + 1;
  localparam int EIW  = maxi(33 - F, 2);
  localparam int NMW  = maxi(16 + MUW - F, 2);
  localparam int CW   = maxi(EIW, NMW) + 1;

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage 1: component products and eta squared
  logic                      v1_q;
  logic signed [15:0]        i1_q [3];
  logic signed [15:0]        n1_q [3];
  logic        [15:0]        eta1_q;
  logic signed [31:0]        pin1_q [3];
  logic        [31:0]        ee1_q;
  logic signed [15:0]        in_i [3];
  logic signed [15:0]        in_n [3];

  assign in_i[0] = in_data_i.incident_x;
  assign in_i[1] = in_data_i.incident_y;
  assign in_i[2] = in_data_i.incident_z;
  assign in_n[0] = in_data_i.normal_x;
  assign in_n[1] = in_data_i.normal_y;
  assign in_n[2] = in_data_i.normal_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        i1_q[c]   <= in_i[c];
        n1_q[c]   <= in_n[c];
        pin1_q[c] <= in_i[c] * in_n[c];
      end
      eta1_q <= in_data_i.eta;
      ee1_q  <= in_data_i.eta * in_data_i.eta;
    end
  end

  // stage 2: dot product floored to q.f
  logic                      v2_q;
  logic signed [15:0]        i2_q [3];
  logic signed [15:0]        n2_q [3];
  logic        [15:0]        eta2_q;
  logic signed [DW-1:0]      d2_q;
  logic        [E2W-1:0]     e2_2_q;
  logic signed [DOTW-1:0]    dot;

  assign dot = DOTW'(pin1_q[0]) + DOTW'(pin1_q[1]) + DOTW'(pin1_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      i2_q   <= i1_q;
      n2_q   <= n1_q;
      eta2_q <= eta1_q;
      d2_q   <= DW'(dot >>> F);
      e2_2_q <= E2W'(ee1_q >> F);
    end
  end

  // stage 3: d*d, eta*d, eta*I
  logic                      v3_q;
  logic signed [15:0]        n3_q [3];
  logic        [E2W-1:0]     e2_3_q;
  logic signed [TW-1:0]      dd3_q;
  logic signed [EDW-1:0]     ed3_q;
  logic signed [EIW-1:0]     ei3_q [3];
  logic signed [2*DW-1:0]    dd_full;
  logic signed [16+DW:0]     ed_full;
  logic signed [16:0]        eta2_s;
  logic signed [32:0]        ei_full [3];

  assign eta2_s  = signed'({1'b0, eta2_q});
  assign dd_full = d2_q * d2_q;
  assign ed_full = eta2_s * d2_q;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ei_full[c] = eta2_s * i2_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n3_q   <= n2_q;
      e2_3_q <= e2_2_q;
      dd3_q  <= TW'(dd_full >>> F);
      ed3_q  <= EDW'(ed_full >>> F);
      for (int c = 0; c < 3; c++) begin
        ei3_q[c] <= EIW'(ei_full[c] >>> F);
      end
    end
  end

  // stage 4: t = 1 - d^2
  logic                      v4_q;
  logic signed [15:0]        n4_q [3];
  logic        [E2W-1:0]     e2_4_q;
  logic signed [TW-1:0]      t4_q;
  logic signed [EDW-1:0]     ed4_q;
  logic signed [EIW-1:0]     ei4_q [3];
  logic signed [TW-1:0]      one_t;

  assign one_t = TW'(64'sd1 <<< F);

  always_ff @(posedge clk_i) begin
    if (en) begin
      n4_q   <= n3_q;
      e2_4_q <= e2_3_q;
      t4_q   <= one_t - dd3_q;
      ed4_q  <= ed3_q;
      ei4_q  <= ei3_q;
    end
  end

  // stage 5: eta^2 * t
  logic                      v5_q;
  logic signed [15:0]        n5_q [3];
  logic signed [PW-1:0]      p5_q;
  logic signed [EDW-1:0]     ed5_q;
  logic signed [EIW-1:0]     ei5_q [3];
  logic signed [E2W+TW:0]    p_full;

  assign p_full = signed'({1'b0, e2_4_q}) * t4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n5_q  <= n4_q;
      p5_q  <= PW'(p_full >>> F);
      ed5_q <= ed4_q;
      ei5_q <= ei4_q;
    end
  end

  // stage 6: k, reflection test and square root radicand
  logic signed [KW-1:0]      k;
  logic                      k_pos;
  logic [2*SW-1:0]           rad;

  assign k     = KW'(64'sd1 <<< F) - KW'(p5_q);
  assign k_pos = !k[KW-1] && (k != '0);
  assign rad   = k_pos ? (2*SW)'({k[KW-2:0], {F{1'b0}}}) : '0;

  // square root stages, index 0 is the stage 6 register
  logic                      sv_q   [SW+1];
  logic signed [15:0]        sn_q   [SW+1][3];
  logic signed [EDW-1:0]     sed_q  [SW+1];
  logic signed [EIW-1:0]     sei_q  [SW+1][3];
  logic                      stir_q [SW+1];
  logic [2*SW-1:0]           srad_q [SW+1];
  logic [RW-1:0]             sr_q   [SW+1];
  logic [SW-1:0]             sq_q   [SW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sn_q[0]   <= n5_q;
      sed_q[0]  <= ed5_q;
      sei_q[0]  <= ei5_q;
      stir_q[0] <= !k_pos;
      srad_q[0] <= rad;
      sr_q[0]   <= '0;
      sq_q[0]   <= '0;
    end
  end

  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    logic [RW-1:0] r_sh;
    logic [RW-1:0] trial;
    logic          fits;

    // bring down the next radicand bit pair and try the next root bit
    assign r_sh  = {sr_q[j][RW-3:0], srad_q[j][2*(SW-1-j)+1 -: 2]};
    assign trial = {sq_q[j], 2'b01};
    assign fits  = (r_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en) begin
        sn_q[j+1]   <= sn_q[j];
        sed_q[j+1]  <= sed_q[j];
        sei_q[j+1]  <= sei_q[j];
        stir_q[j+1] <= stir_q[j];
        srad_q[j+1] <= srad_q[j];
        sr_q[j+1]   <= fits ? (r_sh - trial) : r_sh;
        sq_q[j+1]   <= {sq_q[j][SW-2:0], fits};
      end
    end
  end

  // stage 7: mu = eta*d + sqrt(k)
  logic                      v7_q;
  logic signed [15:0]        n7_q [3];
  logic signed [EIW-1:0]     ei7_q [3];
  logic                      tir7_q;
  logic signed [MUW-1:0]     mu7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n7_q   <= sn_q[SW];
      ei7_q  <= sei_q[SW];
      tir7_q <= stir_q[SW];
      mu7_q  <= MUW'(sed_q[SW]) + MUW'(signed'({1'b0, sq_q[SW]}));
    end
  end

  // stage 8: N * mu
  logic                      v8_q;
  logic signed [EIW-1:0]     ei8_q [3];
  logic                      tir8_q;
  logic signed [NMW-1:0]     nm8_q [3];
  logic signed [15+MUW:0]    nm_full [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      nm_full[c] = n7_q[c] * mu7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ei8_q  <= ei7_q;
      tir8_q <= tir7_q;
      for (int c = 0; c < 3; c++) begin
        nm8_q[c] <= NMW'(nm_full[c] >>> F);
      end
    end
  end

  // stage 9: difference, clamp, output register
  logic signed [CW-1:0]      cdiff [3];
  logic signed [15:0]        cclamp [3];
  logic [2:0]                csat;
  out_t                      out_d;
  out_t                      out_q;
  logic                      v9_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cdiff[c] = CW'(ei8_q[c]) - CW'(nm8_q[c]);
      if (cdiff[c] > CompMax) begin
        cclamp[c] = CompW'(CompMax);
        csat[c]   = 1'b1;
      end else if (cdiff[c] < CompMin) begin
        cclamp[c] = CompW'(CompMin);
        csat[c]   = 1'b1;
      end else begin
        cclamp[c] = CompW'(cdiff[c]);
        csat[c]   = 1'b0;
      end
    end
    if (tir8_q) begin
      out_d = '{out_x: '0, out_y: '0, out_z: '0, total_reflection: 1'b1, saturated: 1'b0};
    end else begin
      out_d = '{out_x: cclamp[0], out_y: cclamp[1], out_z: cclamp[2],
                total_reflection: 1'b0, saturated: |csat};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
      for (int j = 0; j <= SW; j++) begin
        sv_q[j] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      sv_q[0] <= v5_q;
      for (int j = 0; j < SW; j++) begin
        sv_q[j+1] <= sv_q[j];
      end
      v7_q <= sv_q[SW];
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  assign out_valid_o = v9_q;
  assign out_data_o  = out_q;

  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow the output stall");

  a_reflection_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.total_reflection |->
      out_data_o.out_x == '0 && out_data_o.out_y == '0 && out_data_o.out_z == '0
      && !out_data_o.saturated)
    else $error("total reflection result is not the zero vector");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(v8_q) && $stable(tir8_q))
    else $error("pipeline moved during an output stall");

  a_transfer_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !v8_q |=> !out_valid_o)
    else $error("output valid without an item behind it");

endmodule
